### rtl/salt_pkg.sv
// Package with the shared constants and types of the LRU tag lookup.
`default_nettype none
package salt_pkg;
    localparam int unsigned NUM_SETS_DEF   = 64;
    localparam int unsigned NUM_WAYS_DEF   = 4;
    localparam int unsigned LINE_BYTES_DEF = 64;
    localparam int unsigned ADDR_BITS_DEF  = 32;
    localparam int unsigned IN_ADDR_W      = 32;
    localparam int unsigned CNT_W          = 32;

    // One result item.
    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] eviction_count;
    } result_t;

    // Floor of log2, for elaboration only.
    function automatic int unsigned flog2(input int unsigned v);
        int unsigned r;
        int unsigned x;
        r = 0;
        x = v;
        while (x > 1)
        begin
            x = x >> 1;
            r = r + 1;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/salt_if.sv
// Valid/ready channel interfaces for the address and result items.
`default_nettype none
interface salt_addr_if;
    import salt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IN_ADDR_W-1:0] address;
    modport source (output valid, output address, input ready);
    modport sink (input valid, input address, output ready);
endinterface

interface salt_res_if;
    import salt_pkg::*;
    logic             valid;
    logic             ready;
    logic             hit;
    logic             evicted;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] eviction_count;
    modport source (output valid, output hit, output evicted, output hit_count,
                    output miss_count, output eviction_count, input ready);
    modport sink (input valid, input hit, input evicted, input hit_count,
                  input miss_count, input eviction_count, output ready);
endinterface
`default_nettype wire

### rtl/salt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module salt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### rtl/salt_front.sv
// Front part: accepts addresses and splits them into set index and tag.
`default_nettype none
module salt_front
    import salt_pkg::*;
#(
    parameter int unsigned SET_W    = 6,
    parameter int unsigned SET_BITS = 6,
    parameter int unsigned OFF_W    = 6,
    parameter int unsigned TAG_W    = 20
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    salt_addr_if.sink             in_ch,
    input  wire logic             q_ready,
    output logic                  q_valid,
    output logic [SET_W-1:0]      q_set,
    output logic [TAG_W-1:0]      q_tag
);
    localparam int unsigned SW = (SET_W > 0) ? SET_W : 1;
    localparam int unsigned TW = (TAG_W > 0) ? TAG_W : 1;

    logic                 valid_reg;
    logic [SET_W-1:0]     set_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [IN_ADDR_W+63:0] wide_addr;

    assign wide_addr    = {64'd0, in_ch.address};
    assign in_ch.ready  = !valid_reg || q_ready;
    assign q_valid      = valid_reg;
    assign q_set        = set_reg;
    assign q_tag        = tag_reg;

    // Holding register in front of the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    // Address split; bits above the address width read as zero.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            set_reg <= wide_addr[OFF_W +: SW];
            tag_reg <= wide_addr[OFF_W + SET_BITS +: TW];
        end
    end
endmodule
`default_nettype wire

### rtl/salt_back.sv
// Back part: looks up the set, updates valid bits, tags and LRU order, counts.
`default_nettype none
module salt_back
    import salt_pkg::*;
#(
    parameter int unsigned NUM_WAYS = 4,
    parameter int unsigned SET_W    = 6,
    parameter int unsigned TAG_W    = 20
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_valid,
    output logic              q_ready,
    input  wire logic [SET_W-1:0] q_set,
    input  wire logic [TAG_W-1:0] q_tag,
    salt_res_if.source        out_ch
);
    localparam int unsigned WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int unsigned ORD_W   = NUM_WAYS * WAY_W;
    localparam int unsigned ROWS    = 1 << SET_W;
    localparam int unsigned ROW_IW  = (SET_W > 0) ? SET_W : 1;
    localparam int unsigned TROW_W  = NUM_WAYS * TAG_W;
    localparam int unsigned ROW_W   = ORD_W + NUM_WAYS + TROW_W;

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_UPDATE, ST_OUT} state_t;

    state_t                 state_reg;
    logic [ROW_IW-1:0]      clr_reg;
    logic [ROW_IW-1:0]      set_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [CNT_W-1:0]       hits_reg;
    logic [CNT_W-1:0]       misses_reg;
    logic [CNT_W-1:0]       evicts_reg;
    logic                   hit_reg;
    logic                   evicted_reg;
    logic [ROW_W-1:0]       row_rd;
    logic [ROW_W-1:0]       row_wr;
    logic [ROW_W-1:0]       clear_row;
    logic [ROW_W-1:0]       wr_data;
    logic [ROW_IW-1:0]      wr_addr;
    logic [ROW_IW-1:0]      rd_addr;
    logic [TROW_W-1:0]      tag_row;
    logic                   wr_en;
    logic [TROW_W-1:0]      wr_row;

    // Per-lookup combinational results.
    logic [ORD_W-1:0]       cur_order;
    logic [NUM_WAYS-1:0]    cur_valid;
    logic [NUM_WAYS-1:0]    new_valid;
    logic [ORD_W-1:0]       reset_order;
    logic                   hit_found;
    logic                   inv_found;
    logic [WAY_W-1:0]       hit_pos;
    logic [WAY_W-1:0]       inv_pos;
    logic [WAY_W-1:0]       sel_pos;
    logic [WAY_W-1:0]       sel_way;
    logic [ORD_W-1:0]       new_order;

    // Each set row holds its recency order, its valid bits and its tags.
    salt_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_tags (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(row_rd)
    );

    // Reset recency order 0,1,...,NUM_WAYS-1, most recent first.
    always_comb
    begin
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            reset_order[i*WAY_W +: WAY_W] = WAY_W'(i);
        end
    end

    assign clear_row = {reset_order, {NUM_WAYS{1'b0}}, {TROW_W{1'b0}}};
    assign cur_order = row_rd[TROW_W + NUM_WAYS +: ORD_W];
    assign cur_valid = row_rd[TROW_W +: NUM_WAYS];
    assign tag_row   = row_rd[0 +: TROW_W];

    // Search in recency order for a hit and for the first invalid way.
    always_comb
    begin
        logic [WAY_W-1:0] w;
        hit_found = 1'b0;
        inv_found = 1'b0;
        hit_pos   = '0;
        inv_pos   = '0;
        for (int p = 0; p < NUM_WAYS; p++)
        begin
            w = cur_order[p*WAY_W +: WAY_W];
            if (!hit_found && cur_valid[w] && tag_row[w*TAG_W +: TAG_W] == tag_reg)
            begin
                hit_found = 1'b1;
                hit_pos   = WAY_W'(p);
            end
            if (!inv_found && !cur_valid[w])
            begin
                inv_found = 1'b1;
                inv_pos   = WAY_W'(p);
            end
        end
        if (hit_found)
        begin
            sel_pos = hit_pos;
        end
        else if (inv_found)
        begin
            sel_pos = inv_pos;
        end
        else
        begin
            sel_pos = WAY_W'(NUM_WAYS - 1);
        end
        sel_way = cur_order[sel_pos*WAY_W +: WAY_W];
        // Move the selected rank to the front.
        for (int p = 0; p < NUM_WAYS; p++)
        begin
            if (p == 0)
            begin
                new_order[0 +: WAY_W] = sel_way;
            end
            else if (WAY_W'(p) <= sel_pos)
            begin
                new_order[p*WAY_W +: WAY_W] = cur_order[(p-1)*WAY_W +: WAY_W];
            end
            else
            begin
                new_order[p*WAY_W +: WAY_W] = cur_order[p*WAY_W +: WAY_W];
            end
        end
        // A miss fills the selected way.
        new_valid = cur_valid;
        wr_row    = tag_row;
        if (!hit_found)
        begin
            new_valid[sel_way]             = 1'b1;
            wr_row[sel_way*TAG_W +: TAG_W] = tag_reg;
        end
        row_wr = {new_order, new_valid, wr_row};
    end

    // Row port control: clearing pass after reset, then read-modify-write per item.
    assign wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_UPDATE);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_reg : set_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? clear_row : row_wr;
    assign rd_addr = (state_reg == ST_IDLE) ? ROW_IW'(q_set) : set_reg;

    assign q_ready        = (state_reg == ST_IDLE);
    assign out_ch.valid   = (state_reg == ST_OUT);
    assign out_ch.hit            = hit_reg;
    assign out_ch.evicted        = evicted_reg;
    assign out_ch.hit_count      = hits_reg;
    assign out_ch.miss_count     = misses_reg;
    assign out_ch.eviction_count = evicts_reg;

    // Sequencer with state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            evicts_reg   <= '0;
            hit_reg      <= 1'b0;
            evicted_reg  <= 1'b0;
            set_reg      <= '0;
            tag_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ROW_IW'(ROWS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        set_reg   <= ROW_IW'(q_set);
                        tag_reg   <= q_tag;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    hit_reg     <= hit_found;
                    evicted_reg <= !hit_found && !inv_found;
                    if (hit_found)
                    begin
                        hits_reg <= hits_reg + 1'b1;
                    end
                    else
                    begin
                        misses_reg <= misses_reg + 1'b1;
                        if (!inv_found)
                        begin
                            evicts_reg <= evicts_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/set_assoc_lru_tag_lookup_top.sv
// Top level of the set-associative LRU tag lookup.
// Path from address item to result item: front register, RAM read, update, output.
// The back part takes a new item only once the last result has been taken, as it
// does a read-modify-write of a set through the registered tag RAM port.
// Reset (rst_n, asynchronous) clears the counters at once; valid bits and LRU order
// are cleared by a pass over every set (64 by default) while no item is taken.
`default_nettype none
module set_assoc_lru_tag_lookup_top
    import salt_pkg::*;
#(
    parameter int unsigned NUM_SETS   = NUM_SETS_DEF,
    parameter int unsigned NUM_WAYS   = NUM_WAYS_DEF,
    parameter int unsigned LINE_BYTES = LINE_BYTES_DEF,
    parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    salt_addr_if.sink  in_ch,
    salt_res_if.source out_ch
);
    localparam int unsigned OFF_W  = flog2(LINE_BYTES);
    localparam int unsigned SET_WR = flog2(NUM_SETS);
    localparam int unsigned SET_W  = (SET_WR > 0) ? SET_WR : 1;
    localparam int         TBITS   = int'(ADDR_BITS) - int'(OFF_W) - int'(SET_WR);
    localparam int unsigned TAG_W  = (TBITS <= 0) ? 1 :
                                     ((TBITS > 32) ? 32 : TBITS);

    logic             q_valid;
    logic             q_ready;
    logic [SET_W-1:0] q_set;
    logic [TAG_W-1:0] q_tag;
    logic [SET_W-1:0] f_set;
    logic [TAG_W-1:0] f_tag;

    salt_front #(.SET_W(SET_W), .SET_BITS(SET_WR), .OFF_W(OFF_W),
                 .TAG_W(TAG_W)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_ready(q_ready),
        .q_valid(q_valid),
        .q_set  (f_set),
        .q_tag  (f_tag)
    );

    // Zero set index or tag where the geometry leaves none.
    assign q_set = (SET_WR == 0) ? '0 : f_set;
    assign q_tag = (TBITS <= 0) ? '0 : f_tag;

    salt_back #(.NUM_WAYS(NUM_WAYS), .SET_W(SET_W), .TAG_W(TAG_W)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_set  (q_set),
        .q_tag  (q_tag),
        .out_ch (out_ch)
    );

    // An eviction only happens on a miss.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.evicted |-> !out_ch.hit)
        else $error("eviction reported on a hit");

    // Counters hold while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.hit_count)
            && $stable(out_ch.miss_count) && $stable(out_ch.eviction_count))
        else $error("counters moved while result stalled");

    // An evicting result comes with a nonzero miss count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.evicted |-> out_ch.miss_count != '0)
        else $error("eviction without miss");
endmodule
`default_nettype wire

### sim/tb.sv
// Testbench of the set-associative LRU tag lookup: directed and random accesses checked by a predictor.
`default_nettype none
module tb;
    import salt_pkg::*;

    localparam int unsigned SETS  = NUM_SETS_DEF;
    localparam int unsigned WAYS  = NUM_WAYS_DEF;
    localparam int unsigned OBITS = 6;
    localparam int unsigned SBITS = 6;
    localparam int unsigned TBITS = ADDR_BITS_DEF - OBITS - SBITS;
    localparam int unsigned N_RANDOM = 1880;

    logic clk;
    logic rst_n;

    salt_addr_if in_ch();
    salt_res_if  out_ch();

    set_assoc_lru_tag_lookup_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Predictor state: valid bits, tags, recency order per set and running counters.
    logic             way_valid [SETS][WAYS];
    logic [TBITS-1:0] way_tag   [SETS][WAYS];
    int unsigned      lru_rank  [SETS][WAYS];
    logic [CNT_W-1:0] hits_seen, misses_seen, evicts_seen;

    result_t     lookup_q[$];
    int unsigned mismatches;
    bit          stall_long;
    bit          calm;

    // A directed access with a typed-in result where one is obvious.
    typedef struct {
        logic [31:0] addr;
        bit          known;
        logic        hit;
        logic        evicted;
    } access_row_t;

    access_row_t access_table[] = '{
        '{32'h0000_0000, 1'b1, 1'b0, 1'b0},  // first access after reset misses
        '{32'h0000_003F, 1'b1, 1'b1, 1'b0},  // same line, highest offset hits
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},  // all ones: top set, top tag
        '{32'hFFFF_FFC0, 1'b1, 1'b1, 1'b0},
        '{32'h0000_1000, 1'b1, 1'b0, 1'b0},  // fill set 0 with four tags
        '{32'h0000_2000, 1'b1, 1'b0, 1'b0},
        '{32'h0000_3000, 1'b1, 1'b0, 1'b0},
        '{32'h0000_4000, 1'b1, 1'b0, 1'b1},  // set full: evict tag 0
        '{32'h0000_0000, 1'b1, 1'b0, 1'b1},  // evicted line misses again
        '{32'h0000_3000, 1'b0, 1'b0, 1'b0},
        '{32'h0000_5000, 1'b0, 1'b0, 1'b0},
        '{32'h0000_3000, 1'b0, 1'b0, 1'b0},
        '{32'h0000_1000, 1'b0, 1'b0, 1'b0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0},
        '{32'h5555_5555, 1'b0, 1'b0, 1'b0},
        '{32'hFFFF_F000, 1'b0, 1'b0, 1'b0},
        '{32'h8000_0FC0, 1'b0, 1'b0, 1'b0}
    };

    // Clock.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Predicts one lookup and updates the model state.
    function automatic result_t predict_lookup(input logic [31:0] addr);
        result_t          r;
        int unsigned      set_idx;
        logic [TBITS-1:0] tag;
        int               pos;
        int unsigned      w;
        set_idx = (addr >> OBITS) & (SETS - 1);
        tag     = TBITS'(addr >> (OBITS + SBITS));
        pos     = -1;
        r       = '0;
        for (int p = 0; p < WAYS; p++)
        begin
            w = lru_rank[set_idx][p];
            if (pos < 0 && way_valid[set_idx][w] && way_tag[set_idx][w] == tag)
                pos = p;
        end
        if (pos >= 0)
        begin
            r.hit     = 1'b1;
            hits_seen = hits_seen + 1;
        end
        else
        begin
            misses_seen = misses_seen + 1;
            for (int p = 0; p < WAYS; p++)
                if (pos < 0 && !way_valid[set_idx][lru_rank[set_idx][p]])
                    pos = p;
            if (pos < 0)
            begin
                pos         = WAYS - 1;
                r.evicted   = 1'b1;
                evicts_seen = evicts_seen + 1;
            end
            w = lru_rank[set_idx][pos];
            way_valid[set_idx][w] = 1'b1;
            way_tag[set_idx][w]   = tag;
        end
        // Move the touched way to the most recent rank.
        w = lru_rank[set_idx][pos];
        for (int p = pos; p > 0; p--)
            lru_rank[set_idx][p] = lru_rank[set_idx][p-1];
        lru_rank[set_idx][0] = w;
        r.hit_count      = hits_seen;
        r.miss_count     = misses_seen;
        r.eviction_count = evicts_seen;
        return r;
    endfunction

    // Sends one access and records what it should return; returns at the accepting edge.
    task automatic send_access(input logic [31:0] addr, input bit known,
                               input logic exp_hit, input logic exp_evict);
        result_t r;
        int unsigned gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r = predict_lookup(addr);
        if (known && (r.hit !== exp_hit || r.evicted !== exp_evict))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row at %h: exp %b %b got %b %b",
                         addr, exp_hit, exp_evict, r.hit, r.evicted);
        end
        lookup_q.insert(lookup_q.size(), r);
        in_ch.valid   <= 1'b1;
        in_ch.address <= addr;
        // Ready is derived only from registers, so its value at the falling edge holds to the next rising edge.
        @(negedge clk);
        while (!in_ch.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Address, mostly with a tag drawn from a small pool so that sets fill and hit; some are fully random.
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        a = $urandom;
        case ($urandom_range(0, 9))
            0, 1:    ;
            default: a = {20'(a[31:26] % 6), a[11:0]} ^ {2'b00, a[25:24], 28'h0};
        endcase
        return a;
    endfunction

    // Receiver: random stalls and one long hold-off.
    initial
    begin
        int unsigned gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_long)
            begin
                out_ch.ready <= 1'b0;
                for (int c = 0; c < 200; c++)
                    @(posedge clk);
                stall_long = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 11);
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Result checking on items that the next rising edge accepts.
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (lookup_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item hit=%b", out_ch.hit);
            end
            else
            begin
                want = lookup_q.pop_front();
                if (out_ch.hit !== want.hit || out_ch.evicted !== want.evicted ||
                    out_ch.hit_count !== want.hit_count ||
                    out_ch.miss_count !== want.miss_count ||
                    out_ch.eviction_count !== want.eviction_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %b %b %0d %0d %0d got %b %b %0d %0d %0d",
                                 want.hit, want.evicted, want.hit_count,
                                 want.miss_count, want.eviction_count,
                                 out_ch.hit, out_ch.evicted, out_ch.hit_count,
                                 out_ch.miss_count, out_ch.eviction_count);
                end
            end
        end
    end

    // Stimulus.
    initial
    begin
        int unsigned wait_cycles;
        mismatches    = 0;
        stall_long    = 1'b0;
        calm          = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.address = '0;
        rst_n         = 1'b0;
        hits_seen     = '0;
        misses_seen   = '0;
        evicts_seen   = '0;
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++)
            begin
                way_valid[s][w] = 1'b0;
                way_tag[s][w]   = '0;
                lru_rank[s][w]  = w;
            end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (access_table[i])
            send_access(access_table[i].addr, access_table[i].known,
                        access_table[i].hit, access_table[i].evicted);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // Long receiver hold-off while accesses keep coming.
            if (i == 300)
                stall_long = 1'b1;
            // Sender pause until every result is back.
            if (i == 900)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (lookup_q.size() != 0)
                    @(posedge clk);
            end
            if (i == N_RANDOM - 300)
                calm = 1'b1;
            send_access(pick_address(), 1'b0, 1'b0, 1'b0);
        end
        in_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (lookup_q.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0 && lookup_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit.
    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
